// ===== rtl/bbpg_pkg.sv =====
// shared types, constants and the colour function for the background pixel generator
// no dependencies; imported by every module of the block
package bbpg_pkg;

    localparam int COORD_W = 8;
    localparam int CELL_W  = 4;
    localparam int ADDR_W  = 8;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int COLOR_W = 6;
    localparam int MODE_W  = 3;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_QUERY = 3'd0,
        MODE_BOARD = 3'd1,
        MODE_COLX  = 3'd2,
        MODE_ROWY  = 3'd3,
        MODE_PAT   = 3'd4
    } mode_t;

    localparam logic [COLOR_W-1:0] COLOR_BLACK = 6'h20;
    localparam logic [COLOR_W-1:0] COLOR_BOARD = 6'h21;
    localparam logic [COLOR_W-1:0] COLOR_WHITE = 6'h22;
    localparam logic [COLOR_W-1:0] COLOR_STONE = 6'h2f;

    // pattern bit positions
    localparam int PAT_BOARD  = 0;
    localparam int PAT_FRAME  = 1;
    localparam int PAT_STONE  = 2;
    localparam int PAT_CURSOR = 3;

    // board cell bit positions
    localparam int CELL_STONE_BLK  = 0;
    localparam int CELL_STONE_WHT  = 1;
    localparam int CELL_CURSOR_BLK = 2;
    localparam int CELL_CURSOR_WHT = 3;

    // flip offsets and board origin
    localparam logic [COORD_W-1:0] FLIP_X   = 8'd6;    // 262 mod 256
    localparam logic [COORD_W-1:0] FLIP_Y   = 8'd254;
    localparam logic [COORD_W-1:0] COL_BASE = 8'd253;
    localparam logic [COORD_W-1:0] ROW_BASE = 8'd245;

    typedef struct packed {
        logic [COORD_W-1:0] pix_x;
        logic [COORD_W-1:0] pix_y;
        logic [ADDR_W-1:0]  address;
        logic [CELL_W-1:0]  wdata;
    } item_t;

    function automatic logic [COLOR_W-1:0] pixel_color(
        input logic              on,
        input logic [CELL_W-1:0] pat,
        input logic [CELL_W-1:0] cell_bits
    );
        logic [COLOR_W-1:0] c;
        c = COLOR_BLACK;
        if (on) begin
            if (pat[PAT_BOARD] && !pat[PAT_FRAME]) begin
                c = COLOR_BOARD;
            end
            if (pat[PAT_STONE]) begin
                if (cell_bits[CELL_STONE_BLK]) begin
                    c = COLOR_STONE;
                end else if (cell_bits[CELL_STONE_WHT]) begin
                    c = COLOR_WHITE;
                end
            end
            if (pat[PAT_CURSOR]) begin
                if (cell_bits[CELL_CURSOR_BLK]) begin
                    c = COLOR_STONE;
                end else if (cell_bits[CELL_CURSOR_WHT]) begin
                    c = COLOR_WHITE;
                end
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/board_background_pixel_generator.sv =====
// A query is registered in stage 1, stage 2 and the output register before m_tdata.
// Throughput: one item per cycle; the three stages (table read, pattern and board
// read, colour) advance together and stall only while a result is held on the output
// with another query waiting behind it.
// Reset (aresetn, synchronous, active low) clears all valid flags, display_on and the
// per-cell valid bits of the board RAM; column, row and pattern tables hold no reset value.
// Top level of the background pixel generator; uses bbpg_pkg, bbpg_cdiv, bbpg_ram
module board_background_pixel_generator #(
    parameter int CELL_PITCH = 14
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [0:0]                   cfg_data,   // display_on
    // input items
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bbpg_pkg::S_DATA_W-1:0] s_tdata,   // pix_x, pix_y, address, wdata
    input  logic [bbpg_pkg::MODE_W-1:0]  s_tuser,    // mode
    // results
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bbpg_pkg::M_DATA_W-1:0] m_tdata    // dest_x, dest_y, color, zero pad
);
    import bbpg_pkg::*;

    logic  display_on_reg;
    logic  advance;
    logic  out_load;
    logic  accept;
    item_t in_item;
    mode_t in_mode;

    // stage 1
    logic  st1_valid_reg;
    mode_t st1_mode_reg;
    item_t st1_item_reg;

    // stage 2
    logic               st2_valid_reg;
    logic [COORD_W-1:0] st2_x_reg;
    logic [COORD_W-1:0] st2_y_reg;

    // output
    logic               m_tvalid_reg;
    logic [COORD_W-1:0] dest_x_reg;
    logic [COORD_W-1:0] dest_y_reg;
    logic [COLOR_W-1:0] color_reg;

    logic [CELL_W-1:0]  col_q;
    logic [CELL_W-1:0]  row_q;
    logic [CELL_W-1:0]  pat_q;
    logic [COORD_W-1:0] col_quot;
    logic [COORD_W-1:0] row_quot;
    logic [ADDR_W-1:0]  pat_idx;
    logic [ADDR_W-1:0]  cell_idx;

    logic               colx_we;
    logic               rowy_we;
    logic               pat_we;
    logic               board_we;

    logic [CELL_W-1:0]  board_mem [DEPTH];
    logic [DEPTH-1:0]   board_vld_reg;
    logic [CELL_W-1:0]  board_rd_reg;
    logic               board_rd_vld_reg;
    logic [CELL_W-1:0]  cell_val;

    assign in_item = '{pix_x:   s_tdata[7:0],
                       pix_y:   s_tdata[15:8],
                       address: s_tdata[23:16],
                       wdata:   s_tdata[27:24]};
    assign in_mode = mode_t'(s_tuser);

    // output register frees when empty or taken; stages move when it frees or stage 2 holds no query
    assign out_load = !m_tvalid_reg || m_tready;
    assign advance  = out_load || !st2_valid_reg;
    assign accept   = s_tvalid && advance;
    assign s_tready = advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            display_on_reg <= 1'b0;
        end else if (cfg_valid) begin
            display_on_reg <= cfg_data[0];
        end
    end

    // stage 0: column and row table access, divider products
    assign colx_we = accept && (in_mode == MODE_COLX);
    assign rowy_we = accept && (in_mode == MODE_ROWY);

    bbpg_ram u_col_table (
        .aclk  (aclk),
        .en    (advance),
        .we    (colx_we),
        .addr  (colx_we ? in_item.address : in_item.pix_x),
        .wdata (in_item.wdata),
        .rdata (col_q)
    );

    bbpg_ram u_row_table (
        .aclk  (aclk),
        .en    (advance),
        .we    (rowy_we),
        .addr  (rowy_we ? in_item.address : in_item.pix_y),
        .wdata (in_item.wdata),
        .rdata (row_q)
    );

    bbpg_cdiv #(.PITCH(CELL_PITCH), .BASE(COL_BASE)) u_col_div (
        .aclk  (aclk),
        .en    (advance),
        .coord (in_item.pix_x),
        .quot  (col_quot)
    );

    bbpg_cdiv #(.PITCH(CELL_PITCH), .BASE(ROW_BASE)) u_row_div (
        .aclk  (aclk),
        .en    (advance),
        .coord (in_item.pix_y),
        .quot  (row_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (advance) begin
            st1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st1_mode_reg <= in_mode;
            st1_item_reg <= in_item;
        end
    end

    // stage 1: pattern and board access
    assign pat_idx  = {row_q, col_q};
    assign cell_idx = col_quot | {row_quot[CELL_W-1:0], {CELL_W{1'b0}}};
    assign pat_we   = advance && st1_valid_reg && (st1_mode_reg == MODE_PAT);
    assign board_we = advance && st1_valid_reg && (st1_mode_reg == MODE_BOARD);

    bbpg_ram u_pat_table (
        .aclk  (aclk),
        .en    (advance),
        .we    (pat_we),
        .addr  (pat_we ? st1_item_reg.address : pat_idx),
        .wdata (st1_item_reg.wdata),
        .rdata (pat_q)
    );

    always_ff @(posedge aclk) begin
        if (board_we) begin
            board_mem[st1_item_reg.address] <= st1_item_reg.wdata;
        end else if (advance) begin
            board_rd_reg <= board_mem[cell_idx];
        end
    end

    // an unwritten board cell reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_vld_reg <= '0;
        end else if (board_we) begin
            board_vld_reg[st1_item_reg.address] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            board_rd_vld_reg <= board_vld_reg[cell_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (advance) begin
            st2_valid_reg <= st1_valid_reg && (st1_mode_reg == MODE_QUERY);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st2_x_reg <= st1_item_reg.pix_x;
            st2_y_reg <= st1_item_reg.pix_y;
        end
    end

    // stage 2: colour layers and screen flip
    assign cell_val = board_rd_vld_reg ? board_rd_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && st2_valid_reg) begin
            dest_x_reg <= FLIP_X - st2_x_reg;
            dest_y_reg <= FLIP_Y - st2_y_reg;
            color_reg  <= pixel_color(display_on_reg, pat_q, cell_val);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, color_reg, dest_y_reg, dest_x_reg};

    // checks

    a_stall_only_when_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a held result");

    a_query_only_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && st1_valid_reg && st1_mode_reg != MODE_QUERY) |=> !st2_valid_reg)
        else $error("non-query item reached the colour stage");

    a_board_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        board_we |=> board_vld_reg[$past(st1_item_reg.address)])
        else $error("board write did not mark its cell");

    a_color_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (color_reg == COLOR_BLACK || color_reg == COLOR_BOARD ||
                      color_reg == COLOR_WHITE || color_reg == COLOR_STONE))
        else $error("colour outside the palette codes");

    a_held_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(color_reg) && $stable(dest_x_reg)))
        else $error("held result changed");

endmodule

// ===== rtl/bbpg_cdiv.sv =====
// truncating division of (BASE - coordinate) by the cell pitch, result two's complement
// reciprocal multiply registered, then shift and sign; uses bbpg_pkg
module bbpg_cdiv #(
    parameter int PITCH = 14,
    parameter logic [7:0] BASE = 8'd253
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [bbpg_pkg::COORD_W-1:0] coord,
    output logic [bbpg_pkg::COORD_W-1:0] quot
);
    import bbpg_pkg::*;

    // 2^SHIFT covers 255 * 31, so the rounded-up reciprocal is exact for 8-bit operands
    localparam int SHIFT   = 16;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = COORD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << SHIFT) + PITCH - 1) / PITCH);

    logic               neg_next;
    logic [COORD_W-1:0] mag_next;
    logic               neg_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [COORD_W-1:0] q;

    always_comb begin
        if (coord <= BASE) begin
            neg_next = 1'b0;
            mag_next = BASE - coord;
        end else begin
            neg_next = 1'b1;
            mag_next = coord - BASE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg  <= neg_next;
            prod_reg <= PROD_W'(mag_next) * PROD_W'(RECIP);
        end
    end

    assign q    = prod_reg[SHIFT +: COORD_W];
    assign quot = neg_reg ? COORD_W'(-q) : q;

endmodule

// ===== rtl/bbpg_ram.sv =====
// 256 x 4 single-port table with registered read
// used for the column, row and pattern tables; uses bbpg_pkg
module bbpg_ram (
    input  logic                       aclk,
    input  logic                       en,
    input  logic                       we,
    input  logic [bbpg_pkg::ADDR_W-1:0] addr,
    input  logic [bbpg_pkg::CELL_W-1:0] wdata,
    output logic [bbpg_pkg::CELL_W-1:0] rdata
);
    import bbpg_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sim/board_background_pixel_generator_tb.sv =====
// self-checking bench for board_background_pixel_generator: streams table loads, board writes
// and pixel queries under random stalls and checks every result against a local colour predictor
// depends on rtl/bbpg_pkg.sv and the block's rtl sources
`timescale 1ns / 100ps

module board_background_pixel_generator_tb;
    import bbpg_pkg::*;

    localparam int CELL_PITCH  = 14;
    localparam int PIPE_SETTLE = 6;       // cycles for writes still in the pipe to land
    localparam int STALL_LIMIT = 5000;    // cycles with no transfer before giving up
    localparam int MAX_REPORTS = 10;
    localparam int RAND_ON     = 226;
    localparam int RAND_OFF    = 40;

    // modes the block drops without a result
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [COLOR_W-1:0] color;
    } pixel_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [0:0]            cfg_data = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;   // pix_x, pix_y, address, wdata
    logic [MODE_W-1:0]     s_tuser = '0;   // mode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;        // dest_x, dest_y, color, zero pad

    // shadow copy of the block's state
    logic [CELL_W-1:0] board_state [DEPTH];
    logic [CELL_W-1:0] col_lut     [DEPTH];
    logic [CELL_W-1:0] row_lut     [DEPTH];
    logic [CELL_W-1:0] pattern_lut [DEPTH];
    logic              display_en;

    pixel_t expected_pixels[$];
    int     fail_count;
    int     src_idle_pct;
    int     sink_idle_pct;
    int     quiet_cycles;

    board_background_pixel_generator #(
        .CELL_PITCH(CELL_PITCH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [ADDR_W-1:0] board_cell_index(input logic [COORD_W-1:0] x,
                                                           input logic [COORD_W-1:0] y);
        int col_q;
        int row_q;
        // int division truncates toward zero, negatives wrap through the mask
        col_q = (253 - int'(x)) / CELL_PITCH;
        row_q = (245 - int'(y)) / CELL_PITCH;
        return ADDR_W'(col_q | (row_q << 4));
    endfunction

    function automatic pixel_t predict_pixel(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y);
        pixel_t            px;
        logic [CELL_W-1:0] pat;
        logic [CELL_W-1:0] cell_bits;
        px.dest_x = COORD_W'(262 - int'(x));
        px.dest_y = COORD_W'(254 - int'(y));
        px.color  = COLOR_BLACK;
        if (display_en) begin
            pat       = pattern_lut[{row_lut[y], col_lut[x]}];
            cell_bits = board_state[board_cell_index(x, y)];
            if (pat[PAT_BOARD] && !pat[PAT_FRAME]) begin
                px.color = COLOR_BOARD;
            end
            // stone layer, then cursor on top
            if (pat[PAT_STONE] && cell_bits[CELL_STONE_BLK]) begin
                px.color = COLOR_STONE;
            end else if (pat[PAT_STONE] && cell_bits[CELL_STONE_WHT]) begin
                px.color = COLOR_WHITE;
            end
            if (pat[PAT_CURSOR] && cell_bits[CELL_CURSOR_BLK]) begin
                px.color = COLOR_STONE;
            end else if (pat[PAT_CURSOR] && cell_bits[CELL_CURSOR_WHT]) begin
                px.color = COLOR_WHITE;
            end
        end
        return px;
    endfunction

    task automatic shadow_item(input logic [MODE_W-1:0] mode, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y, input logic [ADDR_W-1:0] addr,
                               input logic [7:0] data);
        case (mode)
            MODE_QUERY: expected_pixels.push_back(predict_pixel(x, y));
            MODE_BOARD: board_state[addr] = data[CELL_W-1:0];
            MODE_COLX:  col_lut[addr] = data[CELL_W-1:0];
            MODE_ROWY:  row_lut[addr] = data[CELL_W-1:0];
            MODE_PAT:   pattern_lut[addr] = data[CELL_W-1:0];
            default: ;
        endcase
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [ADDR_W-1:0] addr,
                             input logic [7:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {data, addr, y, x};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        shadow_item(mode, x, y, addr, data);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(negedge aclk);
        end
        repeat (PIPE_SETTLE) @(negedge aclk);
    endtask

    task automatic write_display(input logic on);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= on;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        display_en = on;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [MODE_W-1:0] pick_spare_mode();
        return MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
    endfunction

    task automatic send_random_item(output bit counted);
        int pick;
        logic [MODE_W-1:0] mode;
        pick = $urandom_range(99);
        if (pick < 60) begin
            mode = MODE_QUERY;
        end else if (pick < 75) begin
            mode = MODE_BOARD;
        end else if (pick < 82) begin
            mode = MODE_COLX;
        end else if (pick < 89) begin
            mode = MODE_ROWY;
        end else if (pick < 94) begin
            mode = MODE_PAT;
        end else begin
            mode = pick_spare_mode();
        end
        counted = (mode <= MODE_PAT);
        if (mode == MODE_QUERY && $urandom_range(3) == 0) begin
            // lean on the area past the board edge
            send_item(mode, COORD_W'($urandom_range(255, 230)),
                      COORD_W'($urandom_range(255, 220)),
                      ADDR_W'($urandom_range(255)), 8'($urandom_range(255)));
        end else begin
            send_item(mode, COORD_W'($urandom_range(255)), COORD_W'($urandom_range(255)),
                      ADDR_W'($urandom_range(255)), 8'($urandom_range(255)));
        end
    endtask

    task automatic run_random_items(input int count);
        int  sent;
        bit  counted;
        sent = 0;
        while (sent < count) begin
            send_random_item(counted);
            if (counted) begin
                sent++;
            end
        end
    endtask

    // every table entry is written before any query reads it
    task automatic load_tables();
        for (int i = 0; i < DEPTH; i++) begin
            send_item(MODE_COLX, COORD_W'($urandom_range(255)), COORD_W'($urandom_range(255)),
                      ADDR_W'(i), 8'($urandom_range(255)));
            send_item(MODE_ROWY, COORD_W'($urandom_range(255)), COORD_W'($urandom_range(255)),
                      ADDR_W'(i), 8'($urandom_range(255)));
            send_item(MODE_PAT, COORD_W'($urandom_range(255)), COORD_W'($urandom_range(255)),
                      ADDR_W'(i), 8'($urandom_range(255)));
        end
    endtask

    task automatic test_display_off();
        write_display(1'b0);
        send_item(MODE_QUERY, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(MODE_QUERY, 8'd255, 8'd255, 8'd255, 8'd255);
        send_item(MODE_QUERY, 8'd100, 8'd100, 8'd0, 8'd0);
        send_item(MODE_QUERY, COORD_W'($urandom_range(255)), COORD_W'($urandom_range(255)),
                  8'd0, 8'd0);
    endtask

    task automatic test_layers();
        logic [7:0]        probe_x;
        logic [7:0]        probe_y;
        logic [ADDR_W-1:0] cell_addr;
        logic [3:0]        pats  [6];
        logic [3:0]        cells [6];
        probe_x = 8'd10;
        probe_y = 8'd20;
        // board, frame, black stone, white stone, cursor over stone, white cursor
        pats  = '{4'b0001, 4'b0011, 4'b0101, 4'b0100, 4'b1101, 4'b1111};
        cells = '{4'b0000, 4'b0000, 4'b0001, 4'b0010, 4'b0101, 4'b1010};
        write_display(1'b1);
        send_item(MODE_COLX, 8'd0, 8'd0, probe_x, 8'hf3);
        send_item(MODE_ROWY, 8'd0, 8'd0, probe_y, 8'h05);
        cell_addr = board_cell_index(probe_x, probe_y);
        for (int i = 0; i < 6; i++) begin
            send_item(MODE_PAT, 8'hff, 8'h00, 8'h53, {4'(i * 3), pats[i]});
            send_item(MODE_BOARD, 8'h00, 8'hff, cell_addr, {4'hf - 4'(i), cells[i]});
            send_item(MODE_QUERY, probe_x, probe_y, 8'h00, 8'h00);
        end
    endtask

    task automatic test_edges_and_spare_modes();
        send_item(MODE_QUERY, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(MODE_QUERY, 8'd255, 8'd255, 8'd255, 8'd255);
        send_item(MODE_QUERY, 8'd253, 8'd245, 8'd0, 8'd0);
        send_item(MODE_QUERY, 8'd254, 8'd246, 8'd0, 8'd0);
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
            send_item(MODE_W'(m), COORD_W'($urandom_range(255)), COORD_W'($urandom_range(255)),
                      ADDR_W'($urandom_range(255)), 8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_phase(input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        write_display(1'b1);
        run_random_items(RAND_ON / 2);
        // hold the sender back until the pipe is empty
        drain_results();
        run_random_items(RAND_ON / 2);
        write_display(1'b0);
        run_random_items(RAND_OFF);
    endtask

    initial begin
        fail_count    = 0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        display_en    = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            board_state[i] = '0;
        end
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        load_tables();
        test_display_off();
        test_layers();
        test_edges_and_spare_modes();
        test_random_phase(10, 66);
        test_random_phase(66, 10);
        test_random_phase(0, 0);

        drain_results();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s expected %0h got %0h", $realtime, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        pixel_t want;
        pixel_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[7:0], m_tdata[15:8], m_tdata[21:16]};
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected result, tdata", 0, int'(m_tdata));
            end else begin
                want = expected_pixels.pop_front();
                if (got.dest_x !== want.dest_x) begin
                    report_mismatch("dest_x", int'(want.dest_x), int'(got.dest_x));
                end
                if (got.dest_y !== want.dest_y) begin
                    report_mismatch("dest_y", int'(want.dest_y), int'(got.dest_y));
                end
                if (got.color !== want.color) begin
                    report_mismatch("color", int'(want.color), int'(got.color));
                end
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
